FILE: hdl/fsdb_pkg.sv
`default_nettype none

package fsdb_pkg;

  // Default sizes handed to the top level
  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int FRACTION_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_INTENSITY = 2'd2;

  localparam int IMAGE_WIDTH_W     = 11;
  localparam int IMAGE_HEIGHT_W    = 13;
  localparam int BLEND_INTENSITY_W = 9;

  localparam logic [IMAGE_WIDTH_W-1:0]     IMAGE_WIDTH_RST     = 11'd1024;
  localparam logic [IMAGE_HEIGHT_W-1:0]    IMAGE_HEIGHT_RST    = 13'd1024;
  localparam logic [BLEND_INTENSITY_W-1:0] BLEND_INTENSITY_RST = 9'd256;
  localparam logic [BLEND_INTENSITY_W-1:0] BLEND_FULL          = 9'd256;

  // Number of colour channels that get diffusion
  localparam int NUM_CHAN = 3;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } pix_out_t;

endpackage

`default_nettype wire

FILE: hdl/fsdb_line_store.sv
`default_nettype none

// Line error store: one write and one read port, registered read data,
// with a bypass so that a write to the address held for the waiting pixel
// is seen by it.
module fsdb_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 54
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic [AW-1:0] hold_addr;
  logic          byp_valid;
  logic [DW-1:0] byp_data;
  logic          byp_hit;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Catch writes that land on the address being read or held
  assign byp_hit = wr_en && (rd_en ? (wr_addr == rd_addr) : (wr_addr == hold_addr));

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (rd_en) begin
      byp_valid <= byp_hit;
    end else if (byp_hit) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hold_addr <= rd_addr;
    end
    if (byp_hit) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_valid ? byp_data : mem_q;

endmodule

`default_nettype wire

FILE: hdl/fsdb_chan.sv
`default_nettype none

// One colour channel: add carried error, quantise to one bit, split the
// error into its four floored shares and blend the output byte.
module fsdb_chan #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                           [7:0] pix,
  input  wire logic                                 row_zero,
  input  wire logic signed [FRACTION_BITS+9:0]      stored,
  input  wire logic signed [FRACTION_BITS+9:0]      right,
  input  wire logic signed [FRACTION_BITS+9:0]      pend0,
  input  wire logic signed [FRACTION_BITS+9:0]      pend1,
  input  wire logic                           [8:0] intensity,
  output logic                                [7:0] out_byte,
  output logic signed      [FRACTION_BITS+9:0]      err_left,
  output logic signed      [FRACTION_BITS+9:0]      err_here,
  output logic signed      [FRACTION_BITS+9:0]      err_diag,
  output logic signed      [FRACTION_BITS+9:0]      err_right
);

  localparam int EW = FRACTION_BITS + 10;
  localparam int SW = EW + 2;
  localparam int PW = SW + 3;

  localparam logic signed [SW-1:0] HALF_SCALE = SW'(255 * (2 ** (FRACTION_BITS - 1)));
  localparam logic signed [SW-1:0] FULL_SCALE = SW'(255 * (2 ** FRACTION_BITS));
  localparam logic signed [PW-1:0] SAT_HI     = PW'((2 ** (EW - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_LO     = PW'(-(2 ** (EW - 1)));

  function automatic logic signed [EW-1:0] sat_err(input logic signed [PW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[EW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[EW-1:0];
    end else begin
      r = v[EW-1:0];
    end
    return r;
  endfunction

  logic signed [EW-1:0] stored_eff;
  logic signed [SW-1:0] pix_fx;
  logic signed [SW-1:0] sum;
  logic                 on;
  logic signed [SW-1:0] err;
  logic signed [PW-1:0] err_w;
  logic signed [PW-1:0] s7;
  logic signed [PW-1:0] s5;
  logic signed [PW-1:0] s3;
  logic signed [PW-1:0] s1;
  logic        [8:0]    inv;
  logic        [16:0]   prod;
  logic        [16:0]   dterm;
  logic        [16:0]   total;

  // Quantise pixel plus carried error against half scale
  assign stored_eff = row_zero ? '0 : stored;
  assign pix_fx     = $signed(SW'({pix, {FRACTION_BITS{1'b0}}}));
  assign sum        = pix_fx + SW'(stored_eff) + SW'(right);
  assign on         = (sum >= HALF_SCALE);
  assign err        = on ? (sum - FULL_SCALE) : sum;

  // Floored shares: multiply by shift and add, divide by an arithmetic shift
  assign err_w = PW'(err);
  assign s7    = ((err_w <<< 3) - err_w) >>> 4;
  assign s5    = ((err_w <<< 2) + err_w) >>> 4;
  assign s3    = ((err_w <<< 1) + err_w) >>> 4;
  assign s1    = err_w >>> 4;

  assign err_left  = sat_err(PW'(pend0) + s3);
  assign err_here  = sat_err(PW'(pend1) + s5);
  assign err_diag  = sat_err(s1);
  assign err_right = sat_err(s7);

  // Blend original and dithered byte, rounded
  assign inv      = 9'd256 - intensity;
  assign prod     = 17'(pix) * 17'(inv);
  assign dterm    = on ? (17'({intensity, 8'd0}) - 17'(intensity)) : 17'd0;
  assign total    = prod + dterm + 17'd128;
  assign out_byte = total[15:8];

endmodule

`default_nettype wire

FILE: hdl/floyd_steinberg_rgb_dither_blend.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// cfg      in         cfg_write              cfg_index, cfg_data
// in       in         in_valid / in_ready    in_data  (fsdb_pkg::pix_in_t)
// out      out        out_valid / out_ready  out_data (fsdb_pkg::pix_out_t)
//
// One pixel a cycle while the output is not stalled; each pixel passes from
// the input register, while its line store entry is read, through the
// diffusion and blend logic into the output register.
// After reset a clearing pass writes zero to all MAX_WIDTH line store entries,
// one per cycle, with in_ready low; configuration writes are taken throughout.
// A stalled output holds the pipeline; an empty input register still fills.
module floyd_steinberg_rgb_dither_blend #(
  parameter int MAX_WIDTH     = fsdb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = fsdb_pkg::MAX_HEIGHT_DEF,
  parameter int FRACTION_BITS = fsdb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [fsdb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [fsdb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire fsdb_pkg::pix_in_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output fsdb_pkg::pix_out_t                       out_data
);

  localparam int NC = fsdb_pkg::NUM_CHAN;
  localparam int EW = FRACTION_BITS + 10;
  localparam int DW = NC * EW;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW = (CW + 2 > 12) ? CW + 2 : 12;
  localparam int YW = (RW + 2 > 14) ? RW + 2 : 14;

  // Configuration registers
  logic [fsdb_pkg::IMAGE_WIDTH_W-1:0]     image_width;
  logic [fsdb_pkg::IMAGE_HEIGHT_W-1:0]    image_height;
  logic [fsdb_pkg::BLEND_INTENSITY_W-1:0] blend_intensity;
  logic [fsdb_pkg::BLEND_INTENSITY_W-1:0] intensity;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= fsdb_pkg::IMAGE_WIDTH_RST;
      image_height    <= fsdb_pkg::IMAGE_HEIGHT_RST;
      blend_intensity <= fsdb_pkg::BLEND_INTENSITY_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fsdb_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[fsdb_pkg::IMAGE_WIDTH_W-1:0];
        end
        fsdb_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[fsdb_pkg::IMAGE_HEIGHT_W-1:0];
        end
        fsdb_pkg::REG_BLEND_INTENSITY: begin
          blend_intensity <= cfg_data[fsdb_pkg::BLEND_INTENSITY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign intensity = (blend_intensity > fsdb_pkg::BLEND_FULL) ? fsdb_pkg::BLEND_FULL
                                                               : blend_intensity;

  // Effective frame size
  logic [XW-1:0] w_ext;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_ext;
  logic [YW-1:0] h_eff;

  assign w_ext = XW'(image_width);
  assign h_ext = YW'(image_height);
  assign w_eff = (w_ext == '0) ? XW'(1) :
                 (w_ext > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : w_ext;
  assign h_eff = (h_ext == '0) ? YW'(1) :
                 (h_ext > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : h_ext;

  // Handshake and clearing pass
  logic          clr_active;
  logic [CW-1:0] clr_addr;
  logic          s1_valid;
  logic          adv;
  logic          acc;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_active && (!s1_valid || adv);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + CW'(1);
      if (clr_addr == CW'(MAX_WIDTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Raster position of the next input beat
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          in_last_col;
  logic          in_last_row;

  assign in_last_col = (XW'(column_count) + XW'(1)) >= w_eff;
  assign in_last_row = (YW'(row_count) + YW'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      if (in_last_col) begin
        column_count <= '0;
        row_count    <= in_last_row ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Input register
  fsdb_pkg::pix_in_t s1_pix;
  logic [CW-1:0]     s1_col;
  logic              s1_row_zero;
  logic              s1_last_col;
  logic              s1_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix       <= in_data;
      s1_col       <= column_count;
      s1_row_zero  <= (row_count == '0);
      s1_last_col  <= in_last_col;
      s1_frame_end <= in_last_col && in_last_row;
    end
  end

  // Line store and its write selection
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rd_data;
  logic          pw_valid;
  logic [CW-1:0] pw_addr;
  logic [DW-1:0] pw_data;
  logic          pw_taken;
  logic [DW-1:0] left_word;
  logic [DW-1:0] here_word;

  fsdb_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (acc),
    .rd_addr (column_count),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pw_addr;
    wr_data  = pw_data;
    pw_taken = 1'b0;
    if (clr_active) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (adv && (s1_col != '0)) begin
      wr_en   = 1'b1;
      wr_addr = s1_col - CW'(1);
      wr_data = left_word;
    end else if (adv && s1_last_col) begin
      wr_en   = 1'b1;
      wr_addr = s1_col;
      wr_data = here_word;
    end else if (pw_valid) begin
      wr_en    = 1'b1;
      pw_taken = 1'b1;
    end
  end

  // Hold the own-column write of a row end for the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pw_valid <= 1'b0;
    end else if (adv && s1_last_col && (s1_col != '0)) begin
      pw_valid <= 1'b1;
    end else if (pw_taken) begin
      pw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_col && (s1_col != '0)) begin
      pw_addr <= s1_col;
      pw_data <= here_word;
    end
  end

  // Per-channel diffusion
  logic        [7:0]    s1_byte    [NC];
  logic        [7:0]    res_byte   [NC];
  logic signed [EW-1:0] right_carry [NC];
  logic signed [EW-1:0] pend0      [NC];
  logic signed [EW-1:0] pend1      [NC];
  logic signed [EW-1:0] err_left   [NC];
  logic signed [EW-1:0] err_here   [NC];
  logic signed [EW-1:0] err_diag   [NC];
  logic signed [EW-1:0] err_right  [NC];

  assign s1_byte[0] = s1_pix.pixel_red;
  assign s1_byte[1] = s1_pix.pixel_green;
  assign s1_byte[2] = s1_pix.pixel_blue;

  for (genvar c = 0; c < NC; c++) begin : g_chan
    fsdb_chan #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_chan (
      .pix       (s1_byte[c]),
      .row_zero  (s1_row_zero),
      .stored    ($signed(rd_data[c*EW +: EW])),
      .right     (right_carry[c]),
      .pend0     (pend0[c]),
      .pend1     (pend1[c]),
      .intensity (intensity),
      .out_byte  (res_byte[c]),
      .err_left  (err_left[c]),
      .err_here  (err_here[c]),
      .err_diag  (err_diag[c]),
      .err_right (err_right[c])
    );

    assign left_word[c*EW +: EW] = err_left[c];
    assign here_word[c*EW +: EW] = err_here[c];

    // Advance the row carries; drop them at the end of a row
    always_ff @(posedge clk) begin
      if (rst) begin
        right_carry[c] <= '0;
        pend0[c]       <= '0;
        pend1[c]       <= '0;
      end else if (adv) begin
        if (s1_last_col) begin
          right_carry[c] <= '0;
          pend0[c]       <= '0;
          pend1[c]       <= '0;
        end else begin
          right_carry[c] <= err_right[c];
          pend0[c]       <= err_here[c];
          pend1[c]       <= err_diag[c];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_red   <= res_byte[0];
      out_data.out_green <= res_byte[1];
      out_data.out_blue  <= res_byte[2];
      out_data.out_alpha <= s1_pix.pixel_alpha;
      out_data.frame_end <= s1_frame_end;
    end
  end

endmodule

`default_nettype wire
